### design/rmis_pkg.sv
// ----------------------------------------------------------------------------
// rmis_pkg: shared types and codes of the RAM machine step unit
// Item and result layouts, opcode, mode and status codes, and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rmis_pkg;

	// opcodes
	localparam logic [3:0] KIND_HALT   = 4'd0;
	localparam logic [3:0] KIND_LOAD   = 4'd1;
	localparam logic [3:0] KIND_ADD    = 4'd2;
	localparam logic [3:0] KIND_SUB    = 4'd3;
	localparam logic [3:0] KIND_MULT   = 4'd4;
	localparam logic [3:0] KIND_DIV    = 4'd5;
	localparam logic [3:0] KIND_STORE  = 4'd6;
	localparam logic [3:0] KIND_READ   = 4'd7;
	localparam logic [3:0] KIND_WRITE  = 4'd8;
	localparam logic [3:0] KIND_JUMP   = 4'd9;
	localparam logic [3:0] KIND_JGTZ   = 4'd10;
	localparam logic [3:0] KIND_JZERO  = 4'd11;
	localparam logic [3:0] KIND_JBLANK = 4'd12;

	// operand modes
	localparam logic [1:0] MODE_IMM   = 2'd0;
	localparam logic [1:0] MODE_DIR   = 2'd1;
	localparam logic [1:0] MODE_IND   = 2'd2;
	localparam logic [1:0] MODE_LABEL = 2'd3;

	// machine status codes
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_NEG  = 3'd2;
	localparam logic [2:0] ST_BIG  = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;
	localparam logic [2:0] ST_JUMP = 3'd5;
	localparam logic [2:0] ST_DIV0 = 3'd6;

	localparam logic [15:0] PLEN_RESET = 16'hFFFF;

	typedef struct packed {
		logic [3:0]         kind;
		logic [1:0]         operand_mode;
		logic signed [31:0] operand_value;
		logic               input_available;
		logic signed [31:0] input_value;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        next_pc;
		logic signed [31:0] accumulator;
		logic               write_valid;
		logic signed [31:0] write_value;
		logic               input_taken;
	} result_t;

	typedef logic [15:0] cfg_word_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_wr;    // write one zero entry of the clearing pass
		logic load_item;   // capture an accepted item
		logic set_err;     // record a bad register index
		logic read_op;     // read the register named by the current index
		logic take_ind;    // replace the index by the register read
		logic exec;        // execute and commit the instruction
		logic div_start;   // launch the divider
		logic div_commit;  // commit the quotient
		logic fin_load;    // move the step's report to the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic st_ok;
		logic is_ind;
		logic need_chk;
		logic idx_bad;
		logic is_div;
		logic div_zero;
		logic div_done;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage

### design/rmis_chan_if.sv
// ----------------------------------------------------------------------------
// rmis_chan_if: valid/ready channel
// Carries one payload of type T per handshake.
// ----------------------------------------------------------------------------
interface rmis_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/rmis_ram.sv
// ----------------------------------------------------------------------------
// rmis_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module rmis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### design/rmis_div.sv
// ----------------------------------------------------------------------------
// rmis_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rmis_div import rmis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] mb_q;
	logic        neg_q;

	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, mb_q};
	assign ge      = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			mb_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;
	assign done     = done_q;
endmodule

### design/rmis_datapath.sv
// ----------------------------------------------------------------------------
// rmis_datapath: register file, machine state and execution
// Holds the item, resolves operands through the register file RAM, executes
// and commits under controller commands, and keeps the output register.
// ----------------------------------------------------------------------------
module rmis_datapath import rmis_pkg::*; #(
	parameter int REG_COUNT = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output dp_stat_t  stat,
	input  item_t     item,
	input  logic      cfg_valid,
	input  cfg_word_t cfg_data,
	output result_t   result,
	output logic      result_valid,
	input  logic      result_ready
);
	localparam int IDX_W = $clog2(REG_COUNT);

	// machine state
	logic [2:0]       status_q;
	logic [15:0]      pc_q;
	logic [31:0]      acc_q;
	logic [15:0]      plen_q;
	logic [IDX_W-1:0] clr_q;
	logic             ov_q;

	// item and step registers
	logic [3:0]  kind_q;
	logic [1:0]  mode_q;
	logic [31:0] opv_q;
	logic [31:0] d_q;
	logic        avail_q;
	logic [31:0] inval_q;
	logic        wv_q;
	logic [31:0] wval_q;
	logic        tk_q;
	result_t     res_q;

	logic [31:0] rdata;
	logic        ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0] ram_wdata;
	logic [IDX_W-1:0] idx;

	logic [31:0] quot;
	logic        div_done;

	logic        idx_neg;
	logic        idx_big;
	logic [31:0] x_val;
	logic [31:0] prod;
	logic [31:0] pc_inc;
	logic [31:0] np;
	logic        np_bad;

	logic [2:0]  e_err;
	logic        e_acc_we;
	logic [31:0] e_acc;
	logic        e_ram_we;
	logic [31:0] e_ram_data;
	logic        e_jump;
	logic        e_halt;
	logic        e_wv;
	logic        e_tk;
	logic        exec_ok;

	assign idx     = d_q[IDX_W-1:0];
	assign idx_neg = d_q[31];
	assign idx_big = !d_q[31] && (d_q >= 32'(REG_COUNT));

	assign x_val = (mode_q == MODE_IMM) ? opv_q :
	               (mode_q == MODE_LABEL) ? 32'd0 : rdata;
	assign prod  = acc_q * x_val;

	rmis_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read_op),
		.raddr (idx),
		.rdata (rdata)
	);

	rmis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_q),
		.divisor  (x_val),
		.quotient (quot),
		.done     (div_done)
	);

	always_comb begin
		e_err      = ST_OK;
		e_acc_we   = 1'b0;
		e_acc      = acc_q;
		e_ram_we   = 1'b0;
		e_ram_data = acc_q;
		e_jump     = 1'b0;
		e_halt     = 1'b0;
		e_wv       = 1'b0;
		e_tk       = 1'b0;
		unique case (kind_q)
			KIND_HALT: e_halt = 1'b1;
			KIND_LOAD: begin
				e_acc_we = 1'b1;
				e_acc    = x_val;
			end
			KIND_ADD: begin
				e_acc_we = 1'b1;
				e_acc    = acc_q + x_val;
			end
			KIND_SUB: begin
				e_acc_we = 1'b1;
				e_acc    = acc_q - x_val;
			end
			KIND_MULT: begin
				e_acc_we = 1'b1;
				e_acc    = prod;
			end
			KIND_DIV: begin
				if (x_val == 32'd0) begin
					e_err = ST_DIV0;
				end
			end
			KIND_STORE: e_ram_we = 1'b1;
			KIND_READ: begin
				if (!avail_q) begin
					e_err = ST_READ;
				end else begin
					e_ram_we   = 1'b1;
					e_ram_data = inval_q;
					e_tk       = 1'b1;
					e_acc_we   = (idx == '0);
					e_acc      = inval_q;
				end
			end
			KIND_WRITE:  e_wv = 1'b1;
			KIND_JUMP:   e_jump = 1'b1;
			KIND_JGTZ:   e_jump = (acc_q != 32'd0) && !acc_q[31];
			KIND_JZERO:  e_jump = (acc_q == 32'd0);
			KIND_JBLANK: e_jump = !avail_q;
			default: ;
		endcase
	end

	assign exec_ok = cmd.exec && (e_err == ST_OK);
	assign pc_inc  = {16'd0, pc_q} + 32'd1;
	assign np      = e_jump ? d_q : pc_inc;
	assign np_bad  = np[31] || (np >= {16'd0, plen_q});

	// RAM write port: clearing pass, execution, quotient
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx;
		ram_wdata = e_ram_data;
		priority if (cmd.clear_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.div_commit) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = quot;
		end else if (exec_ok && e_ram_we) begin
			ram_we = 1'b1;
		end else if (exec_ok && e_acc_we) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = e_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			pc_q     <= '0;
			acc_q    <= '0;
			plen_q   <= PLEN_RESET;
			clr_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				plen_q <= cfg_data;
			end
			if (cmd.clear_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.set_err) begin
				status_q <= idx_neg ? ST_NEG : ST_BIG;
			end
			if (cmd.exec) begin
				if (e_err != ST_OK) begin
					status_q <= e_err;
				end else begin
					if (e_acc_we) begin
						acc_q <= e_acc;
					end
					if (e_halt) begin
						status_q <= ST_HALT;
						pc_q     <= pc_q + 16'd1;
					end else if (np_bad) begin
						status_q <= ST_JUMP;
					end else begin
						pc_q <= np[15:0];
					end
				end
			end
			if (cmd.div_commit) begin
				acc_q <= quot;
				if (np_bad) begin
					status_q <= ST_JUMP;
				end else begin
					pc_q <= np[15:0];
				end
			end
			if (cmd.fin_load) begin
				ov_q <= 1'b1;
			end else if (result_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= item.kind;
			mode_q  <= item.operand_mode;
			opv_q   <= item.operand_value;
			d_q     <= item.operand_value;
			avail_q <= item.input_available;
			inval_q <= item.input_value;
			wv_q    <= 1'b0;
			wval_q  <= '0;
			tk_q    <= 1'b0;
		end
		if (cmd.take_ind) begin
			d_q    <= rdata;
			mode_q <= MODE_DIR;
		end
		if (exec_ok) begin
			wv_q   <= e_wv;
			wval_q <= e_wv ? rdata : 32'd0;
			tk_q   <= e_tk;
		end
		if (cmd.fin_load) begin
			res_q.status      <= status_q;
			res_q.next_pc     <= pc_q;
			res_q.accumulator <= acc_q;
			res_q.write_valid <= wv_q;
			res_q.write_value <= wval_q;
			res_q.input_taken <= tk_q;
		end
	end

	assign stat.st_ok    = (status_q == ST_OK);
	assign stat.is_ind   = (mode_q == MODE_IND);
	assign stat.need_chk = (mode_q == MODE_DIR) || (mode_q == MODE_IND) ||
	                       (kind_q == KIND_STORE) || (kind_q == KIND_READ) ||
	                       (kind_q == KIND_WRITE);
	assign stat.idx_bad  = idx_neg || idx_big;
	assign stat.is_div   = (kind_q == KIND_DIV);
	assign stat.div_zero = (x_val == 32'd0);
	assign stat.div_done = div_done;
	assign stat.clr_last = (clr_q == IDX_W'(REG_COUNT - 1));
	assign stat.out_free = !ov_q || result_ready;

	assign result       = res_q;
	assign result_valid = ov_q;
endmodule

### design/rmis_ctrl.sv
// ----------------------------------------------------------------------------
// rmis_ctrl: step sequencer
// Clears the register file after reset, then walks each item through index
// check, operand reads, execution or division, and the output hand-off.
// ----------------------------------------------------------------------------
module rmis_ctrl import rmis_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  dp_stat_t stat,
	output cmd_t     cmd
);
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_CHK   = 7'b0000100,
		S_IND   = 7'b0001000,
		S_EXE   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHK;
				end
			end
			S_CHK: begin
				priority if (!stat.st_ok) begin
					state_d = S_FIN;
				end else if (stat.need_chk && stat.idx_bad) begin
					cmd.set_err = 1'b1;
					state_d     = S_FIN;
				end else if (stat.is_ind) begin
					cmd.read_op = 1'b1;
					state_d     = S_IND;
				end else if (stat.need_chk) begin
					cmd.read_op = 1'b1;
					state_d     = S_EXE;
				end else begin
					state_d = S_EXE;
				end
			end
			S_IND: begin
				cmd.take_ind = 1'b1;
				state_d      = S_CHK;
			end
			S_EXE: begin
				if (stat.is_div && !stat.div_zero) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### design/ram_machine_instruction_step_unit.sv
// ----------------------------------------------------------------------------
// ram_machine_instruction_step_unit: one RAM machine instruction per item
// Top level joining the step sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each item on item_in is one instruction of a random access machine; the
// unit executes it against its register file (register 0 is the
// accumulator), program counter and machine status, and returns one result
// item on result_out with the new status, pc, accumulator, any value put out
// by a write and whether a read consumed the input word. After reset the unit
// clears its REG_COUNT registers, one per cycle, and takes no item during
// that clearing pass; cfg writes of program_length are taken at any time
// (cfg.ready is always high) but are meant for an idle unit. An item passes
// from acceptance to the result register through accept, index check and
// register read, execute and hand-off for immediate, label and direct
// operands; an indirect operand adds a second index check and read through
// the register file's single read port, and div runs an iterative divider
// producing one quotient bit per cycle. A new item is accepted the cycle
// after the previous result was loaded, even while that result still waits
// on result_out. Once a step ends in halt or an error, the state freezes and
// every later item just reports it.
module ram_machine_instruction_step_unit import rmis_pkg::*; #(
	parameter int REG_COUNT = 32
) (
	input logic         clk,
	input logic         arst_n,
	rmis_chan_if.sink   item_in,
	rmis_chan_if.source result_out,
	rmis_chan_if.sink   cfg
);
	cmd_t     cmd;
	dp_stat_t stat;
	item_t    item;
	result_t  result;
	logic     item_ready;
	logic     result_valid;

	// payload views of the channels
	assign item = item_in.data;

	rmis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_in.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rmis_datapath #(.REG_COUNT(REG_COUNT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.cfg_valid    (cfg.valid),
		.cfg_data     (cfg.data),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_out.ready)
	);

	// hold ready high on cfg: program_length is a plain register
	assign cfg.ready        = 1'b1;
	assign item_in.ready    = item_ready;
	assign result_out.valid = result_valid;
	assign result_out.data  = result;
endmodule

### tb/tb_ram_machine_instruction_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ram_machine_instruction_step_unit: self-checking bench for the step unit
// Drives instructions through the item channel and keeps its own copy of the
// machine: registers, pc, status and program length. Each accepted result is
// checked field by field against that copy. Random instructions are screened
// so the machine stays running; one closing test drives it into halt or an
// error picked at random and then checks that the state stays frozen.
// ----------------------------------------------------------------------------
module tb_ram_machine_instruction_step_unit;
	import rmis_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int NUM_REGS       = 32;
	localparam int SETTLE_CYCLES  = 48;    // longest step (div) plus hand-off
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
	localparam int MAX_REPORTS    = 100;

	// kinds 13..15 have no meaning; they only resolve the operand
	localparam logic [3:0] KIND_SPARE_0 = 4'd13;
	localparam logic [3:0] KIND_SPARE_2 = 4'd15;

	// machine copy kept by the bench
	typedef struct packed {
		logic [NUM_REGS-1:0][31:0] rf;
		logic [15:0]               pc;
		logic [2:0]                st;
	} machine_t;

	logic clk;
	logic arst_n;

	rmis_chan_if #(.T(item_t))     item_if ();
	rmis_chan_if #(.T(result_t))   result_if ();
	rmis_chan_if #(.T(cfg_word_t)) cfg_if ();

	ram_machine_instruction_step_unit #(.REG_COUNT(NUM_REGS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_if),
		.result_out(result_if),
		.cfg       (cfg_if)
	);

	machine_t  ram_state;
	logic [15:0] prog_len;
	result_t   pending_steps[$];

	bit    idle_on;
	bit    hold_request;
	int    fail_count;
	int    report_count;
	int    instr_count;
	int    ind_count;
	int    results_checked;
	int    words_out;
	int    plen_writes;
	int    kind_count[16];
	string closing_case;

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic [2:0] index_status(logic [31:0] idx);
		if (idx[31])
			return ST_NEG;
		if (idx >= NUM_REGS)
			return ST_BIG;
		return ST_OK;
	endfunction

	// Signed division truncating toward zero, done on magnitudes so the most
	// negative value over -1 wraps back to itself.
	function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q  = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// Execute one instruction against machine m and report the outcome.
	function automatic void exec_instruction(input item_t it, input logic [15:0] plen,
			inout machine_t m, output result_t r);
		logic [31:0] idx, x, acc, np;
		logic [2:0]  err;
		logic        via_reg, take_jump, wvalid, taken;
		logic [31:0] wvalue;
		idx = it.operand_value;
		x = '0;
		err = ST_OK;
		take_jump = 1'b0;
		wvalid = 1'b0;
		wvalue = '0;
		taken = 1'b0;
		if (m.st == ST_OK) begin
			via_reg = (it.operand_mode == MODE_DIR);
			// indirect: the named register holds the real index
			if (it.operand_mode == MODE_IND) begin
				err = index_status(idx);
				if (err == ST_OK) begin
					idx = m.rf[idx];
					via_reg = 1'b1;
				end
			end
			if (err == ST_OK) begin
				if (it.operand_mode == MODE_IMM)
					x = idx;
				else if (via_reg) begin
					err = index_status(idx);
					if (err == ST_OK)
						x = m.rf[idx];
				end
			end
			if (err == ST_OK && (it.kind == KIND_STORE || it.kind == KIND_READ ||
					it.kind == KIND_WRITE))
				err = index_status(idx);
			if (err == ST_OK) begin
				acc = m.rf[0];
				case (it.kind)
					KIND_HALT:   m.st = ST_HALT;
					KIND_LOAD:   m.rf[0] = x;
					KIND_ADD:    m.rf[0] = acc + x;
					KIND_SUB:    m.rf[0] = acc - x;
					KIND_MULT:   m.rf[0] = acc * x;
					KIND_DIV: begin
						if (x == 0)
							err = ST_DIV0;
						else
							m.rf[0] = quotient(acc, x);
					end
					KIND_STORE:  m.rf[idx] = acc;
					KIND_READ: begin
						if (!it.input_available)
							err = ST_READ;
						else begin
							m.rf[idx] = it.input_value;
							taken = 1'b1;
						end
					end
					KIND_WRITE: begin
						wvalid = 1'b1;
						wvalue = m.rf[idx];
					end
					KIND_JUMP:   take_jump = 1'b1;
					KIND_JGTZ:   take_jump = (acc != 0) && !acc[31];
					KIND_JZERO:  take_jump = (acc == 0);
					KIND_JBLANK: take_jump = !it.input_available;
					default: ;
				endcase
			end
			if (err != ST_OK)
				m.st = err;
			else if (m.st == ST_HALT)
				m.pc = m.pc + 16'd1;   // halt: advance unchecked, wrap at 16 bits
			else begin
				np = take_jump ? idx : {16'd0, m.pc} + 32'd1;
				if (np[31] || np >= plen)
					m.st = ST_JUMP;   // effects stay, pc holds
				else
					m.pc = np[15:0];
			end
		end
		r.status = m.st;
		r.next_pc = m.pc;
		r.accumulator = m.rf[0];
		r.write_valid = wvalid;
		r.write_value = wvalue;
		r.input_taken = taken;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic item_t instr(logic [3:0] k, logic [1:0] md, logic [31:0] v,
			logic av = 1'b1, logic [31:0] iv = '0);
		item_t it;
		it.kind = k;
		it.operand_mode = md;
		it.operand_value = v;
		it.input_available = av;
		it.input_value = iv;
		return it;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random instruction with operands biased toward valid register indexes and
	// jump targets inside the program; halt is left for the closing test.
	function automatic item_t random_instr();
		item_t it;
		int    roll;
		it.kind = 4'($urandom_range(KIND_LOAD, KIND_SPARE_2));
		it.operand_mode = 2'($urandom_range(0, 3));
		roll = $urandom_range(0, 9);
		if (it.kind >= KIND_JUMP && it.kind <= KIND_JBLANK && roll < 7) begin
			if (roll < 2)
				it.operand_value = $urandom_range(prog_len > 8 ? prog_len - 8 : 0,
					prog_len - 1);
			else
				it.operand_value = $urandom_range(0, prog_len - 1);
		end else if (roll < 6)
			it.operand_value = $urandom_range(0, NUM_REGS - 1);
		else
			it.operand_value = $urandom;
		it.input_available = ($urandom_range(0, 7) != 0);
		it.input_value = $urandom_range(0, 1) ? $urandom_range(0, NUM_REGS - 1) : $urandom;
		return it;
	endfunction

	// Screen random candidates on a scratch copy; keep the first that leaves the
	// machine running, else jump back to the start of the program.
	function automatic item_t running_instr();
		machine_t trial;
		result_t  r;
		item_t    cand;
		for (int i = 0; i < 24; i++) begin
			cand = random_instr();
			trial = ram_state;
			exec_instruction(cand, prog_len, trial, r);
			if (r.status == ST_OK)
				return cand;
		end
		return instr(KIND_JUMP, MODE_IMM, 32'd0);
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	// Present one instruction, wait for the handshake and record its outcome.
	task automatic send_instr(input item_t it);
		int      gap;
		result_t r;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			item_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_if.valid <= 1'b1;
		item_if.data <= it;
		do @(posedge clk); while (!item_if.ready);
		exec_instruction(it, prog_len, ram_state, r);
		pending_steps.push_back(r);
		instr_count++;
		kind_count[it.kind]++;
		if (it.operand_mode == MODE_IND)
			ind_count++;
	endtask

	task automatic send_running(input int count);
		repeat (count) send_instr(running_instr());
	endtask

	// Drop the item valid, let the unit drain, then write program_length.
	task automatic write_program_length(input logic [15:0] len);
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= len;
		do @(posedge clk); while (!cfg_if.ready);
		prog_len = len;
		plen_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				stall_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else if (!idle_on || $urandom_range(0, 3) != 0)
				result_if.ready <= 1'b1;
			else begin
				result_if.ready <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			// drop reports past the cap, keep counting
			if (report_count < MAX_REPORTS) begin
				report_count++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		end
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (pending_steps.size() == 0) begin
				fail_count++;
				$error("result with no instruction outstanding");
			end else begin
				want = pending_steps.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
				check_field("accumulator", want.accumulator, got.accumulator);
				check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
				check_field("write_value", want.write_value, got.write_value);
				check_field("input_taken", 32'(want.input_taken), 32'(got.input_taken));
				results_checked++;
				if (got.write_valid)
					words_out++;
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		int quiet_cycles;
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			quiet_cycles = 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else
			quiet_cycles++;
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// Field extremes, every operation but halt, every mode, wraps and the division
	// corners, all at the reset program length.
	task automatic test_directed_ops();
		idle_on = 1'b1;
		send_instr(instr(KIND_LOAD, MODE_IMM, 32'h7FFF_FFFF));
		send_instr(instr(KIND_ADD, MODE_IMM, 32'd1));          // wraps to min
		send_instr(instr(KIND_SUB, MODE_IMM, 32'd1));          // wraps back
		send_instr(instr(KIND_MULT, MODE_IMM, 32'hFFFF_FFFF));
		send_instr(instr(KIND_STORE, MODE_IMM, 32'd31));       // top register
		send_instr(instr(KIND_LOAD, MODE_IMM, 32'h8000_0000));
		send_instr(instr(KIND_DIV, MODE_IMM, 32'hFFFF_FFFF));  // min / -1 overflow
		send_instr(instr(KIND_LOAD, MODE_IMM, -32'sd7));
		send_instr(instr(KIND_DIV, MODE_IMM, 32'd2));          // truncates toward zero
		send_instr(instr(KIND_DIV, MODE_DIR, 32'd31));
		send_instr(instr(KIND_READ, MODE_IMM, 32'd5, 1'b1, 32'd3));
		send_instr(instr(KIND_LOAD, MODE_IND, 32'd5));
		send_instr(instr(KIND_JZERO, MODE_IMM, 32'd40));
		send_instr(instr(KIND_JGTZ, MODE_IMM, 32'd100));       // acc zero: falls through
		send_instr(instr(KIND_READ, MODE_IMM, 32'd0, 1'b1, 32'd25));
		send_instr(instr(KIND_JGTZ, MODE_LABEL, 32'd200));
		send_instr(instr(KIND_JBLANK, MODE_IMM, 32'd7, 1'b1, 32'hFFFF_FFFF));
		send_instr(instr(KIND_JBLANK, MODE_IND, 32'd5, 1'b0, 32'h8000_0000));
		send_instr(instr(KIND_WRITE, MODE_DIR, 32'd31));
		send_instr(instr(KIND_WRITE, MODE_IND, 32'd5));
		send_instr(instr(KIND_SPARE_0, MODE_IMM, 32'h5555_5555));
		send_instr(instr(KIND_SPARE_0 + 4'd1, MODE_DIR, 32'd31));
		send_instr(instr(KIND_SPARE_2, MODE_LABEL, 32'hFFFF_FFFF));
		send_instr(instr(KIND_LOAD, MODE_LABEL, 32'hAAAA_AAAA)); // label operand reads as zero
		send_instr(instr(KIND_LOAD, MODE_IMM, 32'hFFFF_FFFF));
		send_instr(instr(KIND_JGTZ, MODE_IMM, 32'd0));          // negative acc: no jump
		send_instr(instr(KIND_JUMP, MODE_DIR, 32'd31));
	endtask

	// Short program: the pc keeps running into the end and must jump back.
	task automatic test_short_program();
		write_program_length(16'($urandom_range(8, 40)));
		send_running(250);
	endtask

	// One-instruction program: only a taken jump to 0 keeps the machine running.
	task automatic test_single_instruction();
		write_program_length(16'd1);
		send_running(100);
	endtask

	// Largest program, with many jumps aimed at its last instructions.
	task automatic test_max_length();
		write_program_length(PLEN_RESET);
		send_running(300);
	endtask

	// Bulk random instructions over several program lengths, one stretch with
	// no idling on either side.
	task automatic test_random_mix();
		write_program_length(16'($urandom_range(2, 64)));
		send_running(300);
		idle_on = 1'b0;
		write_program_length(16'($urandom_range(65, 4000)));
		send_running(300);
		idle_on = 1'b1;
		write_program_length(PLEN_RESET - 16'd1);
		send_running(300);
		write_program_length(16'($urandom_range(1, 65535)));
		send_running(300);
	endtask

	// Hold the receiver off while instructions keep coming, so the unit fills
	// and stalls its input.
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_request = 1'b1;
		send_running(60);
		idle_on = 1'b1;
	endtask

	// Drive the machine into halt or one error, then check it stays frozen
	// under arbitrary instructions.
	task automatic test_terminal_state();
		logic [31:0] bad_idx;
		logic [15:0] len;
		int          pick;
		write_program_length(PLEN_RESET);
		send_instr(instr(KIND_JUMP, MODE_IMM, 32'd0));
		bad_idx = $urandom_range(0, 1) ? (32'h8000_0000 | $urandom) :
			$urandom_range(NUM_REGS, 32'h7FFF_FFFF);
		pick = $urandom_range(0, 7);
		case (pick)
			0: begin
				// halt: the pc advance past a one-instruction program is not checked
				closing_case = "halt";
				write_program_length(16'd1);
				send_instr(instr(KIND_HALT, MODE_IMM, $urandom));
			end
			1: begin
				closing_case = "negative direct index";
				send_instr(instr(4'($urandom_range(KIND_LOAD, KIND_SPARE_2)), MODE_DIR,
					32'h8000_0000 | $urandom));
			end
			2: begin
				closing_case = "direct index too large";
				send_instr(instr(4'($urandom_range(KIND_LOAD, KIND_SPARE_2)), MODE_DIR,
					$urandom_range(NUM_REGS, 32'h7FFF_FFFF)));
			end
			3: begin
				closing_case = "bad index through indirect register";
				send_instr(instr(KIND_LOAD, MODE_IMM, bad_idx));
				send_instr(instr(KIND_STORE, MODE_IMM, 32'd7));
				send_instr(instr(4'($urandom_range(KIND_LOAD, KIND_SPARE_2)), MODE_IND,
					32'd7));
			end
			4: begin
				closing_case = "store, read or write to a bad register";
				send_instr(instr(4'($urandom_range(KIND_STORE, KIND_WRITE)), MODE_IMM,
					bad_idx));
			end
			5: begin
				closing_case = "read from an empty stream";
				send_instr(instr(KIND_READ, MODE_IMM, $urandom_range(0, NUM_REGS - 1),
					1'b0, $urandom));
			end
			6: begin
				closing_case = "divide by zero";
				send_instr(instr(KIND_LOAD, MODE_IMM, 32'd0));
				send_instr(instr(KIND_STORE, MODE_IMM, 32'd9));
				send_instr(instr(KIND_LOAD, MODE_IMM, $urandom));
				if ($urandom_range(0, 1))
					send_instr(instr(KIND_DIV, MODE_IMM, 32'd0));
				else
					send_instr(instr(KIND_DIV, MODE_DIR, 32'd9));
			end
			default: begin
				closing_case = "jump out of the program";
				len = 16'($urandom_range(2, 1000));
				write_program_length(len);
				case ($urandom_range(0, 2))
					0: send_instr(instr(KIND_JUMP, MODE_IMM, 32'h8000_0000 | $urandom));
					1: send_instr(instr(KIND_JUMP, MODE_LABEL, $urandom_range(len, 65535)));
					default: begin
						// falling off the end keeps the write that caused it
						send_instr(instr(KIND_JUMP, MODE_IMM, len - 1));
						send_instr(instr(KIND_WRITE, MODE_IMM, $urandom_range(0, NUM_REGS - 1)));
					end
				endcase
			end
		endcase
		// frozen: every field fully random
		repeat (10)
			send_instr(instr(4'($urandom), 2'($urandom), $urandom, 1'($urandom),
				$urandom));
		@(negedge clk);
		item_if.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		ram_state = '0;
		prog_len = PLEN_RESET;
		idle_on = 1'b1;
		hold_request = 1'b0;
		closing_case = "none";
		item_if.valid = 1'b0;
		item_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_short_program();
		test_single_instruction();
		test_max_length();
		test_random_mix();
		test_backpressure();
		test_terminal_state();

		// drain, then give stray results a chance to show up
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d instructions (%0d div, %0d indirect) over %0d length settings",
			instr_count, kind_count[KIND_DIV], ind_count, plen_writes);
		$display("Checked %0d results, %0d with an output word; closing case: %s",
			results_checked, words_out, closing_case);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### ram_machine_instruction_step_unit.f
design/rmis_pkg.sv
design/rmis_chan_if.sv
design/rmis_ram.sv
design/rmis_div.sv
design/rmis_datapath.sv
design/rmis_ctrl.sv
design/ram_machine_instruction_step_unit.sv
tb/tb_ram_machine_instruction_step_unit.sv
